### hdl/fprc_pkg.sv
`default_nettype none

package fprc_pkg;

   localparam int FRAME_BUFFER_BYTES_DEF = 32;

   localparam int BYTE_W      = 8;
   localparam int SUM_W       = 16;
   localparam int CMP_W       = BYTE_W + 1;
   localparam int CSR_INDEX_W = 1;
   localparam int STATUS_W    = 3;
   localparam int PIDX_W      = 5;
   localparam int PLEN_W      = 6;

   localparam logic [BYTE_W-1:0] MIN_LEN      = 8'd6;
   localparam logic [BYTE_W-1:0] SOF_BYTE_RST = 8'd170;
   localparam logic [BYTE_W-1:0] EOF_BYTE_RST = 8'd85;

   localparam logic [STATUS_W-1:0] STATUS_NONE = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_OK   = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_CSUM = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_LEN  = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_OVF  = 3'd4;

   localparam logic [CSR_INDEX_W-1:0] CSR_SOF_BYTE = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_EOF_BYTE = 1'd1;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                payload_valid;
      logic [BYTE_W-1:0]   payload_byte;
      logic [PIDX_W-1:0]   payload_index;
      logic [BYTE_W-1:0]   frame_type;
      logic [BYTE_W-1:0]   frame_addr;
      logic [BYTE_W-1:0]   function_code;
      logic [PLEN_W-1:0]   payload_length;
   } result_type;

endpackage

`default_nettype wire

### hdl/framed_packet_receiver_checksum_core.sv
`default_nettype none

// Receives a framed byte stream (start code, length, type, address, function, payload,
// big-endian 16-bit sum checksum, end code) and returns one result word for every
// received word: payload bytes are passed out as they arrive, and the word that ends a
// frame carries its status, with header fields when the checksum matches. The core
// accepts one word per cycle while rsp_ready does not stall it; the rate is set by the
// single frame state update between the input register and the result register, each
// of which takes a new word whenever the stage after it moves on. Start and end codes may
// be written through the csr_ port while no word is in flight.
module framed_packet_receiver_checksum_core #(
   parameter int FRAME_BUFFER_BYTES = fprc_pkg::FRAME_BUFFER_BYTES_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output      logic                             req_ready,
   input  wire logic [fprc_pkg::BYTE_W-1:0]      req_in_byte,
   output      logic                             rsp_valid,
   input  wire logic                             rsp_ready,
   output      logic [fprc_pkg::STATUS_W-1:0]    rsp_status,
   output      logic                             rsp_payload_valid,
   output      logic [fprc_pkg::BYTE_W-1:0]      rsp_payload_byte,
   output      logic [fprc_pkg::PIDX_W-1:0]      rsp_payload_index,
   output      logic [fprc_pkg::BYTE_W-1:0]      rsp_frame_type,
   output      logic [fprc_pkg::BYTE_W-1:0]      rsp_frame_addr,
   output      logic [fprc_pkg::BYTE_W-1:0]      rsp_function_code,
   output      logic [fprc_pkg::PLEN_W-1:0]      rsp_payload_length,
   input  wire logic                             csr_valid,
   output      logic                             csr_ready,
   input  wire logic [fprc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [fprc_pkg::BYTE_W-1:0]      csr_data
);
   import fprc_pkg::*;

   logic              in_valid_ff;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              rsp_valid_ff;
   result_type        rsp_ff;
   result_type        step_result;
   logic [BYTE_W-1:0] sof_byte_ff;
   logic [BYTE_W-1:0] eof_byte_ff;
   logic              step_en;

   assign step_en   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || step_en;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sof_byte_ff <= SOF_BYTE_RST;
         eof_byte_ff <= EOF_BYTE_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_SOF_BYTE: sof_byte_ff <= csr_data;
            CSR_EOF_BYTE: eof_byte_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_byte_ff <= req_in_byte;
      end
   end

   fprc_frame #(
      .FRAME_BUFFER_BYTES(FRAME_BUFFER_BYTES)
   ) u_frame (
      .clock      (clock),
      .reset      (reset),
      .step_en    (step_en),
      .in_byte    (in_byte_ff),
      .sof_byte   (sof_byte_ff),
      .eof_byte   (eof_byte_ff),
      .result_out (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step_en) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         rsp_ff <= step_result;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_ff.status;
   assign rsp_payload_valid  = rsp_ff.payload_valid;
   assign rsp_payload_byte   = rsp_ff.payload_byte;
   assign rsp_payload_index  = rsp_ff.payload_index;
   assign rsp_frame_type     = rsp_ff.frame_type;
   assign rsp_frame_addr     = rsp_ff.frame_addr;
   assign rsp_function_code  = rsp_ff.function_code;
   assign rsp_payload_length = rsp_ff.payload_length;

endmodule

`default_nettype wire

### hdl/fprc_frame.sv
`default_nettype none

module fprc_frame #(
   parameter int FRAME_BUFFER_BYTES = fprc_pkg::FRAME_BUFFER_BYTES_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        step_en,
   input  wire logic [fprc_pkg::BYTE_W-1:0] in_byte,
   input  wire logic [fprc_pkg::BYTE_W-1:0] sof_byte,
   input  wire logic [fprc_pkg::BYTE_W-1:0] eof_byte,
   output fprc_pkg::result_type             result_out
);
   import fprc_pkg::*;

   localparam int POS_W = $clog2(FRAME_BUFFER_BYTES);
   localparam logic [CMP_W-1:0] FBB_X = CMP_W'(FRAME_BUFFER_BYTES);
   localparam logic [CMP_W-1:0] PAYLOAD_FIRST = CMP_W'(5);

   typedef enum logic [1:0] {
      FRAME_IDLE = 2'b01,
      FRAME_OPEN = 2'b10
   } frame_state_type;

   frame_state_type   state_ff, state_in;
   logic [POS_W-1:0]  position_ff, position_in;
   logic [BYTE_W-1:0] len_ff, len_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [SUM_W-1:0]  rsum_ff, rsum_in;
   logic [BYTE_W-1:0] type_ff, type_in;
   logic [BYTE_W-1:0] addr_ff, addr_in;
   logic [BYTE_W-1:0] func_ff, func_in;

   logic [CMP_W-1:0] pos_x;
   logic [CMP_W-1:0] len_x;
   logic [CMP_W-1:0] byte_x;
   logic [CMP_W-1:0] k;

   assign pos_x  = CMP_W'(position_ff);
   assign len_x  = CMP_W'(len_ff);
   assign byte_x = CMP_W'(in_byte);
   assign k      = pos_x + CMP_W'(1);

   always_comb begin
      state_in    = state_ff;
      position_in = position_ff;
      len_in      = len_ff;
      sum_in      = sum_ff;
      rsum_in     = rsum_ff;
      type_in     = type_ff;
      addr_in     = addr_ff;
      func_in     = func_ff;
      result_out  = '0;
      if (state_ff == FRAME_IDLE) begin
         if (in_byte == sof_byte) begin
            state_in    = FRAME_OPEN;
            position_in = '0;
            len_in      = '0;
            sum_in      = '0;
            rsum_in     = '0;
            type_in     = '0;
            addr_in     = '0;
            func_in     = '0;
         end
      end else if ((pos_x != '0) && (pos_x == len_x) && (in_byte == eof_byte)) begin
         state_in = FRAME_IDLE;
         if (sum_ff == rsum_ff) begin
            result_out.status         = STATUS_OK;
            result_out.frame_type     = type_ff;
            result_out.frame_addr     = addr_ff;
            result_out.function_code  = func_ff;
            result_out.payload_length = PLEN_W'(len_ff - MIN_LEN);
         end else begin
            result_out.status = STATUS_CSUM;
         end
      end else begin
         position_in = POS_W'(k);
         if (k == CMP_W'(1)) begin
            len_in = in_byte;
            if ((in_byte < MIN_LEN) || (byte_x > FBB_X)) begin
               result_out.status = STATUS_LEN;
               state_in          = FRAME_IDLE;
            end else begin
               sum_in = sum_ff + SUM_W'(in_byte);
            end
         end else if (k > len_x) begin
            result_out.status = STATUS_LEN;
            state_in          = FRAME_IDLE;
         end else if ((k + CMP_W'(2)) <= len_x) begin
            sum_in = sum_ff + SUM_W'(in_byte);
            if (k == CMP_W'(2)) begin
               type_in = in_byte;
            end else if (k == CMP_W'(3)) begin
               addr_in = in_byte;
            end else if (k == CMP_W'(4)) begin
               func_in = in_byte;
            end else begin
               result_out.payload_valid = 1'b1;
               result_out.payload_byte  = in_byte;
               result_out.payload_index = PIDX_W'(k - PAYLOAD_FIRST);
            end
         end else if ((k + CMP_W'(1)) == len_x) begin
            rsum_in = {in_byte, rsum_ff[BYTE_W-1:0]};
         end else begin
            rsum_in = {rsum_ff[SUM_W-1:BYTE_W], in_byte};
         end
         if ((result_out.status == STATUS_NONE) && ((k + CMP_W'(1)) >= FBB_X)) begin
            result_out.status = STATUS_OVF;
            state_in          = FRAME_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FRAME_IDLE;
      end else if (step_en) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         position_ff <= position_in;
         len_ff      <= len_in;
         sum_ff      <= sum_in;
         rsum_ff     <= rsum_in;
         type_ff     <= type_in;
         addr_ff     <= addr_in;
         func_ff     <= func_in;
      end
   end

   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (step_en && (state_ff == FRAME_IDLE)) |->
      ((result_out.status == STATUS_NONE) && !result_out.payload_valid))
      else $error("idle byte produced a status or payload");

   a_end_goes_idle: assert property (@(posedge clock) disable iff (reset)
      (step_en && (result_out.status != STATUS_NONE)) |=> (state_ff == FRAME_IDLE))
      else $error("frame still open after a final status");

   a_position_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == FRAME_OPEN) |-> (CMP_W'(position_ff) < FBB_X))
      else $error("position beyond frame buffer");

   a_payload_status: assert property (@(posedge clock) disable iff (reset)
      (step_en && result_out.payload_valid) |->
      ((result_out.status == STATUS_NONE) || (result_out.status == STATUS_OVF)))
      else $error("payload word carries a closing status");

endmodule

`default_nettype wire
